// ----- rtl/r2fft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types and constants of the radix-2 complex FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int WORD_BITS     = 28;
    localparam int OUT_BITS      = 26;
    localparam int TW_BITS       = 18;
    localparam int ROM_BITS      = 17;
    localparam int PROD_BITS     = WORD_BITS + TW_BITS;
    localparam int INDEX_BITS    = 10;
    localparam int LOG2_REG_BITS = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 4;
    localparam int ROUND_SHIFT   = 15;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [TW_BITS-1:0]   tw_t;
    typedef logic        [ROM_BITS-1:0]  rom_word_t;

    typedef struct packed {
        word_t re;
        word_t im;
    } cplx_t;

    localparam word_t OUT_MAX = word_t'(33554431);
    localparam word_t OUT_MIN = word_t'(-33554432);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOG2_SIZE = 1'b1;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_RD_OUT = 13'b0000000000010,
        S_PR_RA  = 13'b0000000000100,
        S_PR_RB  = 13'b0000000001000,
        S_PR_W1  = 13'b0000000010000,
        S_PR_W2  = 13'b0000000100000,
        S_BF_RA  = 13'b0000001000000,
        S_BF_RB  = 13'b0000010000000,
        S_BF_MUL = 13'b0000100000000,
        S_BF_SUM = 13'b0001000000000,
        S_BF_WA  = 13'b0010000000000,
        S_BF_WB  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/r2fft_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2fft_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module r2fft_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/r2fft_bfly.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2fft_bfly
// Radix-2 butterfly: twiddle products registered, rounded sums registered,
// then a + t and a - t.
// ----------------------------------------------------------------------------
module r2fft_bfly (
    input  wire logic            aclk,
    input  wire r2fft_pkg::cplx_t a,
    input  wire r2fft_pkg::cplx_t b,
    input  wire r2fft_pkg::tw_t   c,
    input  wire r2fft_pkg::tw_t   s,
    output r2fft_pkg::cplx_t      x,
    output r2fft_pkg::cplx_t      y
);

    localparam int SUM_BITS = r2fft_pkg::PROD_BITS + 2;

    logic signed [r2fft_pkg::PROD_BITS-1:0] p_cr_reg, p_si_reg, p_ci_reg, p_sr_reg;
    logic signed [SUM_BITS-1:0]             sum_re, sum_im;
    r2fft_pkg::word_t                       t_re_reg, t_im_reg;

    always_comb begin
        sum_re = SUM_BITS'(p_cr_reg) + SUM_BITS'(p_si_reg)
               + (SUM_BITS'(1) <<< (r2fft_pkg::ROUND_SHIFT - 1));
        sum_im = SUM_BITS'(p_ci_reg) - SUM_BITS'(p_sr_reg)
               + (SUM_BITS'(1) <<< (r2fft_pkg::ROUND_SHIFT - 1));
    end

    always_ff @(posedge aclk) begin
        p_cr_reg <= c * b.re;
        p_si_reg <= s * b.im;
        p_ci_reg <= c * b.im;
        p_sr_reg <= s * b.re;
        t_re_reg <= r2fft_pkg::word_t'(sum_re >>> r2fft_pkg::ROUND_SHIFT);
        t_im_reg <= r2fft_pkg::word_t'(sum_im >>> r2fft_pkg::ROUND_SHIFT);
    end

    assign x.re = a.re + t_re_reg;
    assign x.im = a.im + t_im_reg;
    assign y.re = a.re - t_re_reg;
    assign y.im = a.im - t_im_reg;

endmodule
`default_nettype wire

// ----- rtl/radix2_complex_fft.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Load request: one load may be accepted every cycle while idle.
// The load that completes a frame runs the transform on the point memory:
// S_PR_RA to S_PR_W2 per index i with rev(i) >= i (S_PR_RA alone otherwise),
// then S_BF_RA to S_BF_WB for (N/2)*log2(N) butterflies on the one butterfly unit.
// Read request: result registered in state S_RD_OUT once the output is free.
// Reset clears control state only; the point memory is undefined until written.
// ----------------------------------------------------------------------------
// radix2_complex_fft
// In-place radix-2 decimation-in-time FFT and inverse FFT on one point memory.
// ----------------------------------------------------------------------------
module radix2_complex_fft #(
    parameter int MAX_LOG2    = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_we,
    input  wire logic [r2fft_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [r2fft_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_func,
    input  wire logic signed [SAMPLE_BITS-1:0]          s_sample_re,
    input  wire logic signed [SAMPLE_BITS-1:0]          s_sample_im,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [r2fft_pkg::OUT_BITS-1:0]       m_bin_re,
    output logic signed [r2fft_pkg::OUT_BITS-1:0]       m_bin_im,
    output logic        [r2fft_pkg::INDEX_BITS-1:0]     m_bin_index,
    output logic                                        m_is_last,
    output logic                                        m_error
);

    localparam int AW      = MAX_LOG2;
    localparam int CW      = AW + 1;
    localparam int KW      = AW + 2;
    localparam int DEPTH   = 1 << MAX_LOG2;
    localparam int QUARTER = DEPTH;
    localparam int LGW     = $clog2(MAX_LOG2 + 1);
    localparam int WB      = r2fft_pkg::WORD_BITS;

    typedef r2fft_pkg::rom_word_t rom_t [QUARTER + 1];

    function automatic rom_t build_cos_rom();
        rom_t              rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            acc;
        for (int i = 0; i <= QUARTER; i++) begin
            x = (r2fft_pkg::PI_Q30 * 64'd2 * longint'(i) + (64'd1 << (MAX_LOG2 + 1)))
                >> (MAX_LOG2 + 2);
            x2 = (x * x + (64'd1 << 29)) >> 30;
            term = 64'd1 << 30;
            acc = longint'(term);
            term = ((term * x2) >> 30) / 64'd2;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd12;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd30;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd56;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd90;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd132;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd182;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd240;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd306;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd380;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd462;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd552;
            acc  = acc + longint'(term);
            if (acc < 0) begin
                acc = 0;
            end
            rom[i] = r2fft_pkg::ROM_BITS'((acc + (64'sd1 << 14)) >>> 15);
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_cos_rom();

    function automatic r2fft_pkg::cplx_t conj_sel(r2fft_pkg::cplx_t v, logic en);
        r2fft_pkg::cplx_t r;
        r.re = v.re;
        r.im = en ? -v.im : v.im;
        return r;
    endfunction

    function automatic logic signed [r2fft_pkg::OUT_BITS-1:0] post_word(
        r2fft_pkg::word_t v, logic inv, logic [LGW-1:0] lg);
        logic signed [WB:0] wide;
        r2fft_pkg::word_t   w;
        wide = {v[WB-1], v};
        if (inv && (lg != '0)) begin
            wide = wide + ((WB+1)'(1) << (lg - LGW'(1)));
            w = r2fft_pkg::word_t'(wide >>> lg);
        end else begin
            w = v;
        end
        if (w > r2fft_pkg::OUT_MAX) begin
            w = r2fft_pkg::OUT_MAX;
        end else if (w < r2fft_pkg::OUT_MIN) begin
            w = r2fft_pkg::OUT_MIN;
        end
        return r2fft_pkg::OUT_BITS'(w);
    endfunction

    r2fft_pkg::state_t state_reg, state_next;

    logic                                   direction_reg;
    logic [r2fft_pkg::LOG2_REG_BITS-1:0]    log2_size_reg;
    logic [CW-1:0]                          load_count_reg;
    logic [CW-1:0]                          read_count_reg;
    logic                                   result_ready_reg;
    logic [LGW-1:0]                         frame_lg_reg;
    logic                                   frame_inv_reg;
    logic [AW-1:0]                          idx_reg;
    logic [LGW-1:0]                         st_reg;
    logic [AW-1:0]                          bf_reg;
    r2fft_pkg::cplx_t                       di_reg;
    r2fft_pkg::cplx_t                       a_reg;
    r2fft_pkg::tw_t                         c_reg, s_reg;
    logic [AW-1:0]                          rd_idx_reg;
    logic                                   rd_last_reg;
    logic                                   rd_err_reg;
    logic                                   m_valid_reg;
    logic signed [r2fft_pkg::OUT_BITS-1:0]  m_bin_re_reg, m_bin_im_reg;
    logic [r2fft_pkg::INDEX_BITS-1:0]       m_bin_index_reg;
    logic                                   m_is_last_reg, m_error_reg;

    logic                s_accept;
    logic                load_req, read_req;
    logic [LGW-1:0]      lg_cur;
    logic [CW-1:0]       n_cur, n_frame;
    logic [AW-1:0]       load_pos, rd_pos;
    logic [CW-1:0]       load_inc, rd_inc;
    logic                frame_full, rd_last;
    logic [AW-1:0]       rev_full, rev_i;
    logic                pass_last, bf_last, stage_last;
    logic [AW-1:0]       h_bit, h_mask, bf_low, addr_a, addr_b;
    logic [LGW:0]        tw_shift;
    logic [KW-1:0]       tw_k, rom_ca, rom_sa;
    logic                tw_upper;
    logic                out_free;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    r2fft_pkg::cplx_t    ram_wdata, ram_rdata;
    r2fft_pkg::cplx_t    load_word;
    r2fft_pkg::cplx_t    bf_x, bf_y;

    assign s_ready  = (state_reg == r2fft_pkg::S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign load_req = s_accept && (s_func == r2fft_pkg::FUNC_LOAD);
    assign read_req = s_accept && (s_func == r2fft_pkg::FUNC_READ);

    assign lg_cur  = (log2_size_reg > MAX_LOG2) ? LGW'(MAX_LOG2) : LGW'(log2_size_reg);
    assign n_cur   = CW'(1) << lg_cur;
    assign n_frame = CW'(1) << frame_lg_reg;

    assign load_pos   = load_count_reg[AW-1:0];
    assign load_inc   = {1'b0, load_pos} + CW'(1);
    assign frame_full = (load_inc >= n_cur);
    assign rd_pos     = read_count_reg[AW-1:0];
    assign rd_inc     = {1'b0, rd_pos} + CW'(1);
    assign rd_last    = (rd_inc >= n_frame);

    assign load_word.re = r2fft_pkg::word_t'(s_sample_re);
    assign load_word.im = r2fft_pkg::word_t'(s_sample_im);

    always_comb begin
        for (int b = 0; b < AW; b++) begin
            rev_full[b] = idx_reg[AW-1-b];
        end
    end
    assign rev_i     = rev_full >> (LGW'(AW) - frame_lg_reg);
    assign pass_last = ({1'b0, idx_reg} == (n_frame - CW'(1)));

    assign h_bit      = AW'(1) << (st_reg - LGW'(1));
    assign h_mask     = h_bit - AW'(1);
    assign bf_low     = bf_reg & h_mask;
    assign addr_a     = ((bf_reg & ~h_mask) << 1) | bf_low;
    assign addr_b     = addr_a | h_bit;
    assign bf_last    = ({1'b0, bf_reg} == ((n_frame >> 1) - CW'(1)));
    assign stage_last = (st_reg == frame_lg_reg);

    assign tw_shift = (LGW+1)'(MAX_LOG2 + 2) - {1'b0, st_reg};
    assign tw_k     = KW'(bf_low) << tw_shift;
    assign tw_upper = (tw_k > KW'(QUARTER));
    assign rom_ca   = tw_upper ? (KW'(2 * QUARTER) - tw_k) : tw_k;
    assign rom_sa   = tw_upper ? (tw_k - KW'(QUARTER)) : (KW'(QUARTER) - tw_k);

    assign out_free = !m_valid_reg || m_ready;

    r2fft_ram #(
        .WIDTH (2 * WB),
        .DEPTH (DEPTH)
    ) u_point_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    r2fft_bfly u_bfly (
        .aclk (aclk),
        .a    (a_reg),
        .b    (ram_rdata),
        .c    (c_reg),
        .s    (s_reg),
        .x    (bf_x),
        .y    (bf_y)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_a;
        ram_wdata = bf_x;
        ram_raddr = rd_pos;
        case (state_reg)
            r2fft_pkg::S_IDLE: begin
                ram_raddr = rd_pos;
                if (load_req) begin
                    ram_we    = 1'b1;
                    ram_waddr = load_pos;
                    ram_wdata = load_word;
                end
            end
            r2fft_pkg::S_RD_OUT: ram_raddr = rd_idx_reg;
            r2fft_pkg::S_PR_RA:  ram_raddr = idx_reg;
            r2fft_pkg::S_PR_RB:  ram_raddr = rev_i;
            r2fft_pkg::S_PR_W1: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = conj_sel(ram_rdata, frame_inv_reg);
            end
            r2fft_pkg::S_PR_W2: begin
                ram_we    = 1'b1;
                ram_waddr = rev_i;
                ram_wdata = conj_sel(di_reg, frame_inv_reg);
            end
            r2fft_pkg::S_BF_RA:  ram_raddr = addr_a;
            r2fft_pkg::S_BF_RB:  ram_raddr = addr_b;
            r2fft_pkg::S_BF_MUL: ram_raddr = addr_b;
            r2fft_pkg::S_BF_WA: begin
                ram_we    = 1'b1;
                ram_waddr = addr_a;
                ram_wdata = bf_x;
            end
            r2fft_pkg::S_BF_WB: begin
                ram_we    = 1'b1;
                ram_waddr = addr_b;
                ram_wdata = bf_y;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            r2fft_pkg::S_IDLE: begin
                if (read_req) begin
                    state_next = r2fft_pkg::S_RD_OUT;
                end else if (load_req && frame_full) begin
                    state_next = r2fft_pkg::S_PR_RA;
                end
            end
            r2fft_pkg::S_RD_OUT: begin
                if (out_free) begin
                    state_next = r2fft_pkg::S_IDLE;
                end
            end
            r2fft_pkg::S_PR_RA: begin
                if (rev_i >= idx_reg) begin
                    state_next = r2fft_pkg::S_PR_RB;
                end else if (pass_last) begin
                    state_next = r2fft_pkg::S_BF_RA;
                end
            end
            r2fft_pkg::S_PR_RB: state_next = r2fft_pkg::S_PR_W1;
            r2fft_pkg::S_PR_W1: state_next = r2fft_pkg::S_PR_W2;
            r2fft_pkg::S_PR_W2: begin
                if (!pass_last) begin
                    state_next = r2fft_pkg::S_PR_RA;
                end else if (frame_lg_reg == '0) begin
                    state_next = r2fft_pkg::S_DONE;
                end else begin
                    state_next = r2fft_pkg::S_BF_RA;
                end
            end
            r2fft_pkg::S_BF_RA:  state_next = r2fft_pkg::S_BF_RB;
            r2fft_pkg::S_BF_RB:  state_next = r2fft_pkg::S_BF_MUL;
            r2fft_pkg::S_BF_MUL: state_next = r2fft_pkg::S_BF_SUM;
            r2fft_pkg::S_BF_SUM: state_next = r2fft_pkg::S_BF_WA;
            r2fft_pkg::S_BF_WA:  state_next = r2fft_pkg::S_BF_WB;
            r2fft_pkg::S_BF_WB: begin
                if (bf_last && stage_last) begin
                    state_next = r2fft_pkg::S_DONE;
                end else begin
                    state_next = r2fft_pkg::S_BF_RA;
                end
            end
            r2fft_pkg::S_DONE: state_next = r2fft_pkg::S_IDLE;
            default: state_next = r2fft_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= r2fft_pkg::S_IDLE;
            direction_reg    <= 1'b0;
            log2_size_reg    <= r2fft_pkg::LOG2_REG_BITS'(10);
            load_count_reg   <= '0;
            read_count_reg   <= '0;
            result_ready_reg <= 1'b0;
            frame_lg_reg     <= '0;
            frame_inv_reg    <= 1'b0;
            idx_reg          <= '0;
            st_reg           <= LGW'(1);
            bf_reg           <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    r2fft_pkg::REG_DIRECTION: direction_reg <= cfg_data[0];
                    r2fft_pkg::REG_LOG2_SIZE: log2_size_reg <= cfg_data;
                    default: direction_reg <= direction_reg;
                endcase
            end

            if (load_req) begin
                result_ready_reg <= 1'b0;
                if (frame_full) begin
                    load_count_reg <= '0;
                    read_count_reg <= '0;
                    frame_lg_reg   <= lg_cur;
                    frame_inv_reg  <= direction_reg;
                    idx_reg        <= '0;
                    st_reg         <= LGW'(1);
                    bf_reg         <= '0;
                end else begin
                    load_count_reg <= load_inc;
                end
            end

            if (read_req && result_ready_reg) begin
                if (rd_last) begin
                    result_ready_reg <= 1'b0;
                    read_count_reg   <= '0;
                end else begin
                    read_count_reg <= rd_inc;
                end
            end

            if (state_reg == r2fft_pkg::S_PR_RA && rev_i < idx_reg && !pass_last) begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (state_reg == r2fft_pkg::S_PR_W2 && !pass_last) begin
                idx_reg <= idx_reg + AW'(1);
            end

            if (state_reg == r2fft_pkg::S_BF_WB) begin
                if (bf_last) begin
                    bf_reg <= '0;
                    st_reg <= st_reg + LGW'(1);
                end else begin
                    bf_reg <= bf_reg + AW'(1);
                end
            end

            if (state_reg == r2fft_pkg::S_DONE) begin
                result_ready_reg <= 1'b1;
            end

            if (state_reg == r2fft_pkg::S_RD_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (read_req) begin
            rd_idx_reg  <= rd_pos;
            rd_last_reg <= rd_last;
            rd_err_reg  <= !result_ready_reg;
        end
        if (state_reg == r2fft_pkg::S_PR_RB) begin
            di_reg <= ram_rdata;
        end
        if (state_reg == r2fft_pkg::S_BF_RA) begin
            c_reg <= tw_upper ? -r2fft_pkg::tw_t'(COS_ROM[rom_ca[AW:0]])
                              : r2fft_pkg::tw_t'(COS_ROM[rom_ca[AW:0]]);
            s_reg <= r2fft_pkg::tw_t'(COS_ROM[rom_sa[AW:0]]);
        end
        if (state_reg == r2fft_pkg::S_BF_RB) begin
            a_reg <= ram_rdata;
        end
        if (state_reg == r2fft_pkg::S_RD_OUT && out_free) begin
            if (rd_err_reg) begin
                m_bin_re_reg    <= '0;
                m_bin_im_reg    <= '0;
                m_bin_index_reg <= '0;
                m_is_last_reg   <= 1'b0;
                m_error_reg     <= 1'b1;
            end else begin
                m_bin_re_reg    <= post_word(ram_rdata.re, frame_inv_reg, frame_lg_reg);
                m_bin_im_reg    <= post_word(frame_inv_reg ? -ram_rdata.im : ram_rdata.im,
                                             frame_inv_reg, frame_lg_reg);
                m_bin_index_reg <= r2fft_pkg::INDEX_BITS'(rd_idx_reg);
                m_is_last_reg   <= rd_last_reg;
                m_error_reg     <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_re    = m_bin_re_reg;
    assign m_bin_im    = m_bin_im_reg;
    assign m_bin_index = m_bin_index_reg;
    assign m_is_last   = m_is_last_reg;
    assign m_error     = m_error_reg;

    a_read_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        read_req |=> (state_reg == r2fft_pkg::S_RD_OUT))
        else $error("Accepted read request did not reach the output stage.");

    a_full_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_req && frame_full) |=> (state_reg == r2fft_pkg::S_PR_RA) && !result_ready_reg)
        else $error("Completing load did not start the transform.");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (m_bin_re == '0) && (m_bin_im == '0) && !m_is_last)
        else $error("Error result carries data.");

    a_done_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == r2fft_pkg::S_DONE) |=> result_ready_reg)
        else $error("Finished transform not marked ready.");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != r2fft_pkg::S_IDLE) |-> !s_accept && !ram_we
            || (state_reg == r2fft_pkg::S_PR_W1) || (state_reg == r2fft_pkg::S_PR_W2)
            || (state_reg == r2fft_pkg::S_BF_WA) || (state_reg == r2fft_pkg::S_BF_WB))
        else $error("Point memory written outside a write step.");

endmodule
`default_nettype wire

// ----- tb/tb_radix2_complex_fft.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix2_complex_fft
// Self-checking bench for the radix-2 FFT: loads and reads are sent over the
// request channel, and every returned bin is compared with an FFT computed
// in the bench on its own copy of the point memory and registers.
// ----------------------------------------------------------------------------
module tb_radix2_complex_fft;

    localparam int LG_MAX    = 10;
    localparam int NPTS      = 1 << LG_MAX;
    localparam int IDLE_MAX  = 400000;

    typedef struct packed {
        logic signed [r2fft_pkg::OUT_BITS-1:0] re;
        logic signed [r2fft_pkg::OUT_BITS-1:0] im;
        logic [r2fft_pkg::INDEX_BITS-1:0]      idx;
        logic                                  last;
        logic                                  err;
    } bin_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [r2fft_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [r2fft_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = r2fft_pkg::FUNC_LOAD;
    logic signed [15:0] s_sample_re = '0;
    logic signed [15:0] s_sample_im = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [r2fft_pkg::OUT_BITS-1:0] m_bin_re;
    logic signed [r2fft_pkg::OUT_BITS-1:0] m_bin_im;
    logic [r2fft_pkg::INDEX_BITS-1:0] m_bin_index;
    logic m_is_last;
    logic m_error;

    radix2_complex_fft u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_sample_re(s_sample_re), .s_sample_im(s_sample_im),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_bin_re(m_bin_re), .m_bin_im(m_bin_im), .m_bin_index(m_bin_index),
        .m_is_last(m_is_last), .m_error(m_error)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bench copy of the block state.
    longint cos_tab [0:NPTS];
    longint mem_re [0:NPTS-1];
    longint mem_im [0:NPTS-1];
    int     fill_count;
    int     bin_count;
    bit     frame_done;
    int     frame_lg;
    bit     dir_inverse;
    int     size_reg;
    int     settle_cycles;

    bin_t   bin_queue[$];
    int     idle_mode;
    int     hold_cycles;
    int     errors;
    int     n_loads, n_reads, n_bins, n_frames;
    int     idle_count;

    function automatic longint wrap28(longint v);
        logic [r2fft_pkg::WORD_BITS-1:0] w;
        w = v[r2fft_pkg::WORD_BITS-1:0];
        return longint'(signed'(w));
    endfunction

    function automatic logic signed [r2fft_pkg::OUT_BITS-1:0] clip26(longint v);
        if (v > 33554431) v = 33554431;
        if (v < -33554432) v = -33554432;
        return v[r2fft_pkg::OUT_BITS-1:0];
    endfunction

    task automatic build_cos_table();
        longint unsigned x, x2, term;
        longint acc;
        for (int i = 0; i <= NPTS; i++) begin
            x = (r2fft_pkg::PI_Q30 * 2 * i + (64'd1 << (LG_MAX + 1))) >> (LG_MAX + 2);
            x2 = (x * x + (64'd1 << 29)) >> 30;
            term = 64'd1 << 30;
            acc = longint'(term);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) acc -= longint'(term);
                else acc += longint'(term);
            end
            if (acc < 0) acc = 0;
            cos_tab[i] = (acc + (1 << 14)) >>> 15;
        end
    endtask

    task automatic fft_in_place(int lg, bit inverse);
        int n, r, h, a, b, k;
        longint c, s, br, bi, ar, ai, tr, ti, t, half;
        n = 1 << lg;
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int q = 0; q < lg; q++) r |= ((i >> q) & 1) << (lg - 1 - q);
            if (r > i) begin
                t = mem_re[i]; mem_re[i] = mem_re[r]; mem_re[r] = t;
                t = mem_im[i]; mem_im[i] = mem_im[r]; mem_im[r] = t;
            end
        end
        if (inverse)
            for (int i = 0; i < n; i++) mem_im[i] = wrap28(-mem_im[i]);
        for (int st = 1; st <= lg; st++) begin
            h = 1 << (st - 1);
            for (int base = 0; base < n; base += 2 * h) begin
                for (int j = 0; j < h; j++) begin
                    a = base + j;
                    b = a + h;
                    k = j << (LG_MAX + 2 - st);
                    if (k <= NPTS) begin
                        c = cos_tab[k];
                        s = cos_tab[NPTS - k];
                    end else begin
                        c = -cos_tab[2 * NPTS - k];
                        s = cos_tab[k - NPTS];
                    end
                    br = mem_re[b]; bi = mem_im[b];
                    ar = mem_re[a]; ai = mem_im[a];
                    tr = (c * br + s * bi + (1 << 14)) >>> 15;
                    ti = (c * bi - s * br + (1 << 14)) >>> 15;
                    mem_re[a] = wrap28(ar + tr);
                    mem_im[a] = wrap28(ai + ti);
                    mem_re[b] = wrap28(ar - tr);
                    mem_im[b] = wrap28(ai - ti);
                end
            end
        end
        if (inverse) begin
            for (int i = 0; i < n; i++) begin
                ar = mem_re[i];
                ai = wrap28(-mem_im[i]);
                if (lg > 0) begin
                    half = longint'(1) << (lg - 1);
                    ar = (ar + half) >>> lg;
                    ai = (ai + half) >>> lg;
                end
                mem_re[i] = wrap28(ar);
                mem_im[i] = wrap28(ai);
            end
        end
    endtask

    task automatic predict_request(logic func, logic signed [15:0] re, logic signed [15:0] im);
        int lg, n, pos;
        bin_t b;
        lg = (size_reg > LG_MAX) ? LG_MAX : size_reg;
        if (func == r2fft_pkg::FUNC_LOAD) begin
            n_loads++;
            pos = fill_count % NPTS;
            mem_re[pos] = re;
            mem_im[pos] = im;
            frame_done = 1'b0;
            fill_count = pos + 1;
            if (fill_count >= (1 << lg)) begin
                fft_in_place(lg, dir_inverse);
                n_frames++;
                frame_lg = lg;
                fill_count = 0;
                bin_count = 0;
                frame_done = 1'b1;
                n = 1 << lg;
                settle_cycles = 4 * n + 3 * n * lg + 50;
            end
        end else begin
            n_reads++;
            b = '0;
            if (!frame_done) begin
                b.err = 1'b1;
            end else begin
                pos = bin_count % NPTS;
                b.re = clip26(mem_re[pos]);
                b.im = clip26(mem_im[pos]);
                b.idx = pos[r2fft_pkg::INDEX_BITS-1:0];
                b.last = (pos + 1 >= (1 << frame_lg));
                bin_count = pos + 1;
                if (b.last) begin
                    frame_done = 1'b0;
                    bin_count = 0;
                end
            end
            bin_queue.push_back(b);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin
        bin_t want;
        if (aresetn && m_valid && m_ready) begin
            n_bins++;
            if (bin_queue.size() == 0) begin
                report_mismatch("unexpected bins", 1, 0);
            end else begin
                want = bin_queue.pop_front();
                if (m_error !== want.err) report_mismatch("error", m_error, want.err);
                if (m_bin_re !== want.re) report_mismatch("bin_re", m_bin_re, want.re);
                if (m_bin_im !== want.im) report_mismatch("bin_im", m_bin_im, want.im);
                if (m_bin_index !== want.idx)
                    report_mismatch("bin_index", m_bin_index, want.idx);
                if (m_is_last !== want.last) report_mismatch("is_last", m_is_last, want.last);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready = 1'b0;
        end else if (idle_mode == 2) begin
            m_ready = ($urandom_range(99) >= 65);
        end else if (idle_mode == 3) begin
            m_ready = ($urandom_range(99) >= 22);
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= IDLE_MAX) begin
            $display("watchdog expired after %0d idle cycles", IDLE_MAX);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(logic func, logic signed [15:0] re, logic signed [15:0] im);
        int gap;
        gap = 0;
        if (idle_mode == 1 && $urandom_range(99) < 65) gap = $urandom_range(1, 4);
        if (idle_mode == 3 && $urandom_range(99) < 22) gap = $urandom_range(1, 4);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_func = func;
        s_sample_re = re;
        s_sample_im = im;
        s_valid = 1'b1;
        #1;
        while (!s_ready) begin
            @(negedge aclk);
            #1;
        end
        @(posedge aclk);
        predict_request(func, re, im);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (bin_queue.size() != 0) @(posedge aclk);
        repeat (settle_cycles) @(posedge aclk);
        settle_cycles = 0;
    endtask

    task automatic write_reg(logic [r2fft_pkg::CFG_IDX_BITS-1:0] idx, int value);
        drain_results();
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value[r2fft_pkg::CFG_DATA_BITS-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == r2fft_pkg::REG_DIRECTION) dir_inverse = value[0];
        else size_reg = value[r2fft_pkg::CFG_DATA_BITS-1:0];
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic load_frame(int n);
        for (int i = 0; i < n; i++)
            send_request(r2fft_pkg::FUNC_LOAD, pick_sample(), pick_sample());
    endtask

    task automatic read_bins(int n);
        for (int i = 0; i < n; i++)
            send_request(r2fft_pkg::FUNC_READ, 16'($urandom()), 16'($urandom()));
    endtask

    task automatic test_read_without_frame();
        read_bins(2);
    endtask

    task automatic test_single_point();
        write_reg(r2fft_pkg::REG_LOG2_SIZE, 0);
        send_request(r2fft_pkg::FUNC_LOAD, 16'sh7fff, 16'sh8000);
        read_bins(2);
    endtask

    task automatic test_forward_extremes();
        write_reg(r2fft_pkg::REG_DIRECTION, 0);
        write_reg(r2fft_pkg::REG_LOG2_SIZE, 3);
        for (int i = 0; i < 8; i++)
            send_request(r2fft_pkg::FUNC_LOAD, (i % 2) ? 16'sh8000 : 16'sh7fff, 16'sh8000);
        read_bins(8);
    endtask

    task automatic test_inverse();
        write_reg(r2fft_pkg::REG_DIRECTION, 1);
        write_reg(r2fft_pkg::REG_LOG2_SIZE, 2);
        load_frame(4);
        read_bins(4);
    endtask

    task automatic test_size_shrink();
        write_reg(r2fft_pkg::REG_DIRECTION, 0);
        write_reg(r2fft_pkg::REG_LOG2_SIZE, 3);
        load_frame(5);
        write_reg(r2fft_pkg::REG_LOG2_SIZE, 2);
        load_frame(1);
        read_bins(4);
    endtask

    task automatic test_load_in_readout();
        write_reg(r2fft_pkg::REG_LOG2_SIZE, 2);
        load_frame(4);
        read_bins(2);
        load_frame(4);
        read_bins(5);
    endtask

    task automatic test_oversize_frame();
        write_reg(r2fft_pkg::REG_DIRECTION, 1);
        write_reg(r2fft_pkg::REG_LOG2_SIZE, 15);
        load_frame(NPTS);
        read_bins(12);
    endtask

    task automatic test_backpressure();
        write_reg(r2fft_pkg::REG_LOG2_SIZE, 4);
        load_frame(16);
        drain_results();
        hold_cycles = 300;
        read_bins(16);
    endtask

    task automatic test_random(int budget);
        int start, lg, n;
        start = n_loads + n_reads;
        while (n_loads + n_reads - start < budget) begin
            idle_mode = $urandom_range(3);
            write_reg(r2fft_pkg::REG_DIRECTION, $urandom_range(1));
            lg = ($urandom_range(9) == 0) ? $urandom_range(7, 8) : $urandom_range(0, 5);
            write_reg(r2fft_pkg::REG_LOG2_SIZE, lg);
            n = 1 << lg;
            if ($urandom_range(5) == 0) read_bins(1);
            load_frame(n);
            case ($urandom_range(5))
                0: read_bins($urandom_range(0, n - 1));
                1: read_bins(n + $urandom_range(1, 2));
                default: read_bins(n);
            endcase
        end
    endtask

    initial begin
        errors = 0;
        n_loads = 0; n_reads = 0; n_bins = 0; n_frames = 0;
        idle_count = 0; hold_cycles = 0; idle_mode = 0; settle_cycles = 0;
        fill_count = 0; bin_count = 0; frame_done = 0; frame_lg = 0;
        dir_inverse = 0; size_reg = 10;
        for (int i = 0; i < NPTS; i++) begin
            mem_re[i] = 0;
            mem_im[i] = 0;
        end
        build_cos_table();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_read_without_frame();
        test_single_point();
        test_forward_extremes();
        test_inverse();
        test_size_shrink();
        test_load_in_readout();
        test_oversize_frame();
        test_backpressure();
        test_random(1850 - (n_loads + n_reads) > 600 ? 1850 - (n_loads + n_reads) : 600);

        idle_mode = 0;
        drain_results();
        repeat (20) @(posedge aclk);
        $display("Run covered %0d loads, %0d reads, %0d transforms and %0d bins returned,",
                 n_loads, n_reads, n_frames, n_bins);
        $display("over both directions, sizes 1 to 1024 and every idling pattern.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches found", errors);
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/r2fft_pkg.sv
rtl/r2fft_ram.sv
rtl/r2fft_bfly.sv
rtl/radix2_complex_fft.sv
tb/tb_radix2_complex_fft.sv
